FILE: rtl/core/lz77_sliding_window_encoder_unit_macros.svh
// Assertion macros shared by the LZ77 sliding-window encoder RTL.
`ifndef LZ77_SLIDING_WINDOW_ENCODER_UNIT_MACROS_SVH
`define LZ77_SLIDING_WINDOW_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define LZSW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define LZSW_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/lzsw_pkg.sv
// Shared types and constants of the LZ77 sliding-window encoder.
package lzsw_pkg;

  // Width of back-offset values on the cell chain (covers windows up to 4096)
  localparam int unsigned LzBackW = 13;

  localparam logic [4:0] WindowReset = 5'd10;

  // Broadcast from the top level to every cell
  typedef struct packed {
    logic               start;   // phrase start: candidates come from window limit
    logic               search;  // length below saturation, comparisons enabled
    logic [LzBackW-1:0] limit;   // min(window, history fill)
  } lz_bcast_t;

  // Update strobe for cell state
  typedef struct packed {
    logic take;   // word accepted this cycle
    logic keep;   // phrase continues: latch new match marks
  } lz_upd_t;

  // Smallest-offset priority chain, one path for new marks, one for held marks
  typedef struct packed {
    logic               found_n;
    logic [LzBackW-1:0] off_n;
    logic               found_a;
    logic [LzBackW-1:0] off_a;
  } lz_pick_t;

endpackage

FILE: rtl/core/lzsw_if.sv
// Handshake channels of the LZ77 encoder: input word, result word, config write.
interface lzsw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface lzsw_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] match_offset;
  logic [7:0] match_length;
  logic [7:0] next_char;
  logic       char_present;
  logic       stream_end;
  modport source (output valid, match_offset, match_length, next_char, char_present,
                  stream_end, input ready);
  modport sink (input valid, match_offset, match_length, next_char, char_present,
                stream_end, output ready);
endinterface

interface lzsw_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] window_size;
  modport source (output valid, window_size, input ready);
  modport sink (input valid, window_size, output ready);
endinterface

FILE: rtl/core/lzsw_cell.sv
// One window cell: holds a history byte and its match mark at a fixed offset.
module lzsw_cell import lzsw_pkg::*; #(
  parameter int unsigned BACK = 1
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] byte_i,   // incoming word, broadcast
  input  logic [7:0] shift_i,  // history byte from the newer neighbour
  output logic [7:0] shift_o,
  input  lz_bcast_t  bc_i,
  input  lz_upd_t    upd_i,
  input  lz_pick_t   pick_i,
  output lz_pick_t   pick_o,
  output logic       alive_o
);

  localparam logic [LzBackW-1:0] MyOff = LzBackW'(BACK);

  logic [7:0] hist_q;
  logic       alive_q, alive_d;
  logic       cand, hit;

  // Candidate at phrase start comes from the window limit, later from the mark
  assign cand = bc_i.start ? (MyOff <= bc_i.limit) : alive_q;
  assign hit  = bc_i.search && cand && (hist_q == byte_i);

  // Priority chain: the nearest offset already found wins
  always_comb begin
    pick_o.found_n = pick_i.found_n | hit;
    pick_o.off_n   = pick_i.found_n ? pick_i.off_n : MyOff;
    pick_o.found_a = pick_i.found_a | alive_q;
    pick_o.off_a   = pick_i.found_a ? pick_i.off_a : MyOff;
  end

  assign alive_d = upd_i.take ? (upd_i.keep & hit) : alive_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q <= 1'b0;
    end else begin
      alive_q <= alive_d;
    end
  end

  // History shifts one cell older per accepted word
  always_ff @(posedge clk_i) begin
    if (upd_i.take) begin
      hist_q <= shift_i;
    end
  end

  assign shift_o = hist_q;
  assign alive_o = alive_q;

endmodule

FILE: rtl/core/lz77_sliding_window_encoder_unit.sv
// LZ77 sliding-window encoder: a row of window cells compares each word against all offsets.
// A triple is registered and shown in the cycle after the word that ends its phrase is accepted.
// Throughput: one word per cycle unless a stalled result blocks input; every offset cell compares in the same cycle.
// A stalled result blocks input only when the output register is full and not taken.
// Reset (rst_ni low, asynchronous) clears history fill, match marks, length and output valid;
// window_size returns to 10.
module lz77_sliding_window_encoder_unit import lzsw_pkg::*; #(
  parameter int unsigned MAX_WINDOW = 16,
  parameter int unsigned MAX_MATCH  = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lzsw_in_if.sink     in_i,
  lzsw_out_if.source  out_o,
  lzsw_cfg_if.sink    cfg_i
);

`include "lz77_sliding_window_encoder_unit_macros.svh"

  localparam int unsigned OFF_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned LEN_W = $clog2(MAX_MATCH + 1);
  localparam int unsigned CMP_W = (OFF_W > 5) ? OFF_W : 5;

  logic [4:0]       wsize_q;
  logic [OFF_W-1:0] hcount_q, hcount_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W:0]   len_inc;

  logic [CMP_W-1:0] wsize_ext, maxw_ext, win_ext;
  logic [OFF_W-1:0] win;

  lz_bcast_t  bc;
  lz_upd_t    upd;
  lz_pick_t   pick [MAX_WINDOW+1];
  logic [7:0] hist [MAX_WINDOW+1];
  logic [MAX_WINDOW-1:0] alive;

  logic take, any, keep;

  logic       out_valid_q, out_valid_d;
  logic [4:0] off_q, off_d;
  logic [7:0] olen_q, olen_d;
  logic [7:0] char_q, char_d;
  logic       pres_q, pres_d;
  logic       end_q, end_d;

  logic [LzBackW+4:0] off_n_ext, off_a_ext;
  logic [LEN_W+8:0]   len_inc_ext;
  logic [LEN_W+7:0]   len_ext;

  // Configuration port, always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wsize_q <= WindowReset;
    end else if (cfg_i.valid) begin
      wsize_q <= cfg_i.window_size;
    end
  end

  // Effective window, clamped to the cell count
  assign wsize_ext = CMP_W'(wsize_q);
  assign maxw_ext  = CMP_W'(MAX_WINDOW);
  assign win_ext   = (wsize_ext > maxw_ext) ? maxw_ext : wsize_ext;
  assign win       = win_ext[OFF_W-1:0];

  // Broadcast to cells
  assign bc.start  = (len_q == '0);
  assign bc.search = (len_q != LEN_W'(MAX_MATCH));
  assign bc.limit  = LzBackW'((win < hcount_q) ? win : hcount_q);

  assign take     = in_i.valid && in_i.ready;
  assign any      = pick[MAX_WINDOW].found_n;
  assign keep     = any && !in_i.last_byte;
  assign upd.take = take;
  assign upd.keep = keep;

  assign pick[0] = '0;
  assign hist[0] = in_i.data_byte;

  // Row of window cells, nearest offset first
  for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
    lzsw_cell #(
      .BACK (g + 1)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .byte_i  (in_i.data_byte),
      .shift_i (hist[g]),
      .shift_o (hist[g+1]),
      .bc_i    (bc),
      .upd_i   (upd),
      .pick_i  (pick[g]),
      .pick_o  (pick[g+1]),
      .alive_o (alive[g])
    );
  end

  // Output fields, masked to their widths
  assign len_inc     = {1'b0, len_q} + {{LEN_W{1'b0}}, 1'b1};
  assign off_n_ext   = {5'b0, pick[MAX_WINDOW].off_n};
  assign off_a_ext   = {5'b0, pick[MAX_WINDOW].off_a};
  assign len_inc_ext = {8'b0, len_inc};
  assign len_ext     = {8'b0, len_q};

  // Phrase length, history fill and result word
  always_comb begin
    len_d       = len_q;
    hcount_d    = hcount_q;
    off_d       = off_q;
    olen_d      = olen_q;
    char_d      = char_q;
    pres_d      = pres_q;
    end_d       = end_q;
    out_valid_d = out_valid_q && !out_o.ready;
    if (take) begin
      if (keep) begin
        len_d = len_inc[LEN_W-1:0];
      end else begin
        len_d       = '0;
        out_valid_d = 1'b1;
        if (any) begin
          // stream ended inside a match
          off_d  = off_n_ext[4:0];
          olen_d = len_inc_ext[7:0];
          char_d = 8'd0;
          pres_d = 1'b0;
          end_d  = 1'b1;
        end else begin
          off_d  = pick[MAX_WINDOW].found_a ? off_a_ext[4:0] : 5'd0;
          olen_d = len_ext[7:0];
          char_d = in_i.data_byte;
          pres_d = 1'b1;
          end_d  = in_i.last_byte;
        end
      end
      if (in_i.last_byte) begin
        hcount_d = '0;
      end else if (hcount_q != OFF_W'(MAX_WINDOW)) begin
        hcount_d = hcount_q + OFF_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      hcount_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      hcount_q    <= hcount_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q  <= off_d;
    olen_q <= olen_d;
    char_q <= char_d;
    pres_q <= pres_d;
    end_q  <= end_d;
  end

  assign in_i.ready         = !out_valid_q || out_o.ready;
  assign out_o.valid        = out_valid_q;
  assign out_o.match_offset = off_q;
  assign out_o.match_length = olen_q;
  assign out_o.next_char    = char_q;
  assign out_o.char_present = pres_q;
  assign out_o.stream_end   = end_q;

  // Checks
  `LZSW_ASSERT_IMP(a_marks_track_len, clk_i, rst_ni, 1'b1, ((len_q == '0) == (alive == '0)), "match marks disagree with phrase length")
  `LZSW_ASSERT_IMP(a_len_bound, clk_i, rst_ni, 1'b1, (len_q <= LEN_W'(MAX_MATCH)), "phrase length above saturation")
  `LZSW_ASSERT_NXT(a_last_clears_fill, clk_i, rst_ni, (take && in_i.last_byte), (hcount_q == '0 && len_q == '0), "stream end did not clear state")
  `LZSW_ASSERT_IMP(a_nochar_is_end, clk_i, rst_ni, (out_valid_q && !pres_q), end_q, "missing literal outside stream end")

endmodule
